// File: hw/rtl/iae_pkg.sv
package iae_pkg;

  // Formula number and fixed-point format
  localparam int MAX_DIGITS = 10;
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 64;

  // log2(10) ~ 3.322: bits for MAX_DIGITS decimal digits
  localparam int ACC_W  = (MAX_DIGITS * 3322) / 1000 + 1;
  localparam int DCNT_W = $clog2(MAX_DIGITS + 1);

  localparam logic [DATA_W-1:0] POS_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] NEG_MIN   = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] NUM_LIMIT = POS_MAX >> FRAC_BITS;

  // Iterative unit: one bit per cycle
  localparam int MUL_STEPS = DATA_W;
  localparam int DIV_STEPS = DATA_W - 1 + FRAC_BITS;
  localparam int MAX_STEPS = (DIV_STEPS > MUL_STEPS) ? DIV_STEPS : MUL_STEPS;
  localparam int CNT_W     = $clog2(MAX_STEPS);
  localparam int DVD_W     = DIV_STEPS;

  // Character codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_MUL,
    OP_DIV
  } pend_op_t;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_ADD,
    CLS_SUB,
    CLS_MUL,
    CLS_DIV,
    CLS_OTHER
  } char_cls_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_DIGIT,
    DP_NUM,
    DP_STEP,
    DP_WB,
    DP_TERM,
    DP_TERM_ADD,
    DP_TERM_SUB,
    DP_PEND_MUL,
    DP_PEND_DIV,
    DP_RESULT
  } dp_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NUM,
    S_UNIT,
    S_WB,
    S_POST,
    S_RES
  } state_t;

  typedef struct packed {
    pend_op_t pend;
    logic     num_zero;
    logic     unit_last;
  } dp_stat_t;

  function automatic char_cls_t char_class(input logic [7:0] c);
    char_cls_t k;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      k = CLS_DIGIT;
    end else if (c == CH_PLUS) begin
      k = CLS_ADD;
    end else if (c == CH_MINUS) begin
      k = CLS_SUB;
    end else if (c == CH_STAR) begin
      k = CLS_MUL;
    end else if (c == CH_SLASH) begin
      k = CLS_DIV;
    end else begin
      k = CLS_OTHER;
    end
    return k;
  endfunction

endpackage

// File: hw/rtl/iae_if.sv
interface iae_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface iae_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [iae_pkg::DATA_W-1:0]  result_value;
  logic        [1:0]                   status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

// File: hw/rtl/iae_dp.sv
module iae_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [7:0]                        char_code,
  input  iae_pkg::dp_op_t                   op,
  output iae_pkg::dp_stat_t                 stat,
  output logic signed [iae_pkg::DATA_W-1:0] result_value,
  output logic [1:0]                        status
);
  import iae_pkg::*;

  // Formula state
  logic [ACC_W-1:0]  acc;
  logic [DCNT_W-1:0] dcnt;
  logic [DATA_W-1:0] term;
  pend_op_t          pend;
  logic [DATA_W-1:0] sum;
  logic              sign;
  logic              err_div0;
  logic              err_ovf;

  // Shift/add multiplier and restoring divider
  logic              unit_div;
  logic [DATA_W-1:0] op_a;
  logic [DATA_W-1:0] op_b;
  logic [DATA_W-1:0] hi;
  logic [DATA_W-1:0] lo;
  logic [DVD_W-1:0]  dvd;
  logic              dovf;
  logic [CNT_W-1:0]  cnt;

  logic [7:0]          digit_raw;
  logic [ACC_W-1:0]    acc_step;
  logic                num_sat;
  logic [DATA_W-1:0]   num_fx;
  logic [DATA_W:0]     mul_sum;
  logic [DATA_W:0]     div_trial;
  logic                div_ge;
  logic [DATA_W:0]     div_diff;
  logic [2*DATA_W-1:0] prod;
  logic                mul_ovf;
  logic [DATA_W-1:0]   mul_res;
  logic                div_ovf;
  logic [DATA_W:0]     term_sum;
  logic                term_sat;
  logic [DATA_W-1:0]   sum_new;

  always_comb begin
    digit_raw = char_code - CH_ZERO;
    acc_step  = ACC_W'({acc, 3'b000} + {acc, 1'b0}) + ACC_W'(digit_raw[3:0]);
    num_sat   = DATA_W'(acc) > NUM_LIMIT;
    num_fx    = num_sat ? POS_MAX : (DATA_W'(acc) << FRAC_BITS);

    mul_sum   = {1'b0, hi} + (op_b[0] ? {1'b0, op_a} : {(DATA_W+1){1'b0}});
    div_trial = {hi, dvd[DVD_W-1]};
    div_ge    = div_trial >= {1'b0, op_b};
    div_diff  = div_trial - {1'b0, op_b};

    prod    = {hi, lo};
    mul_ovf = |prod[2*DATA_W-1:FRAC_BITS+DATA_W-1];
    mul_res = prod[FRAC_BITS+DATA_W-1:FRAC_BITS];
    div_ovf = dovf | lo[DATA_W-1];

    // Term is never negative; only one direction can overflow
    term_sum = sign ? ({sum[DATA_W-1], sum} - {1'b0, term})
                    : ({sum[DATA_W-1], sum} + {1'b0, term});
    term_sat = term_sum[DATA_W] != term_sum[DATA_W-1];
    sum_new  = term_sat ? (sign ? NEG_MIN : POS_MAX) : term_sum[DATA_W-1:0];
  end

  always_comb begin
    stat.pend      = pend;
    stat.num_zero  = acc == '0;
    stat.unit_last = cnt == (unit_div ? CNT_W'(DIV_STEPS - 1) : CNT_W'(MUL_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      dcnt     <= '0;
      term     <= '0;
      pend     <= OP_NONE;
      sum      <= '0;
      sign     <= 1'b0;
      err_div0 <= 1'b0;
      err_ovf  <= 1'b0;
    end else begin
      case (op)
        DP_DIGIT: begin
          // drop digits past the limit
          if (dcnt < DCNT_W'(MAX_DIGITS)) begin
            acc  <= acc_step;
            dcnt <= dcnt + 1'b1;
          end
        end
        DP_NUM: begin
          acc  <= '0;
          dcnt <= '0;
          pend <= OP_NONE;
          if (num_sat) begin
            err_ovf <= 1'b1;
          end
          case (pend)
            OP_MUL: ;
            OP_DIV: begin
              if (acc == '0) begin
                err_div0 <= 1'b1;
                term     <= '0;
              end
            end
            default: term <= num_fx;
          endcase
        end
        DP_WB: begin
          if (unit_div) begin
            term <= div_ovf ? POS_MAX : lo;
            if (div_ovf) begin
              err_ovf <= 1'b1;
            end
          end else begin
            term <= mul_ovf ? POS_MAX : mul_res;
            if (mul_ovf) begin
              err_ovf <= 1'b1;
            end
          end
        end
        DP_TERM, DP_TERM_ADD, DP_TERM_SUB: begin
          sum  <= sum_new;
          term <= '0;
          if (term_sat) begin
            err_ovf <= 1'b1;
          end
          if (op == DP_TERM_ADD) begin
            sign <= 1'b0;
          end else if (op == DP_TERM_SUB) begin
            sign <= 1'b1;
          end
        end
        DP_PEND_MUL: pend <= OP_MUL;
        DP_PEND_DIV: pend <= OP_DIV;
        DP_RESULT: begin
          acc      <= '0;
          dcnt     <= '0;
          term     <= '0;
          pend     <= OP_NONE;
          sum      <= '0;
          sign     <= 1'b0;
          err_div0 <= 1'b0;
          err_ovf  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      DP_NUM: begin
        unit_div <= pend == OP_DIV;
        op_a     <= term;
        op_b     <= num_fx;
        hi       <= '0;
        lo       <= '0;
        dvd      <= DVD_W'(term) << FRAC_BITS;
        dovf     <= 1'b0;
        cnt      <= '0;
      end
      DP_STEP: begin
        cnt <= cnt + 1'b1;
        if (unit_div) begin
          // restoring step: remainder in hi, quotient in lo
          dvd <= dvd << 1;
          hi  <= div_ge ? div_diff[DATA_W-1:0] : div_trial[DATA_W-1:0];
          lo  <= {lo[DATA_W-2:0], div_ge};
          if (lo[DATA_W-1] | lo[DATA_W-2]) begin
            dovf <= 1'b1;
          end
        end else begin
          // shift/add step: product shifts right through hi:lo
          hi   <= mul_sum[DATA_W:1];
          lo   <= {mul_sum[0], lo[DATA_W-1:1]};
          op_b <= op_b >> 1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (op == DP_RESULT) begin
      result_value <= err_div0 ? '0 : sum;
      status       <= err_div0 ? ST_DIV0 : (err_ovf ? ST_OVF : ST_OK);
    end
  end

endmodule

// File: hw/rtl/iae_ctrl.sv
module iae_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        char_code,
  input  logic              last_char,
  output logic              out_valid,
  input  logic              out_ready,
  output iae_pkg::dp_op_t   op,
  input  iae_pkg::dp_stat_t stat
);
  import iae_pkg::*;

  state_t    state;
  state_t    state_next;
  char_cls_t cls;
  char_cls_t cls_next;
  char_cls_t cls_in;
  logic      last_q;
  logic      last_next;
  logic      final_q;
  logic      final_next;
  logic      out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cls       <= CLS_OTHER;
      last_q    <= 1'b0;
      final_q   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cls     <= cls_next;
      last_q  <= last_next;
      final_q <= final_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cls_next   = cls;
    last_next  = last_q;
    final_next = final_q;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    op         = DP_NOP;
    cls_in     = char_class(char_code);

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cls_next   = cls_in;
          last_next  = last_char;
          final_next = 1'b0;
          case (cls_in)
            CLS_DIGIT, CLS_OTHER: begin
              if (cls_in == CLS_DIGIT) begin
                op = DP_DIGIT;
              end
              if (last_char) begin
                final_next = 1'b1;
                state_next = S_NUM;
              end
            end
            default: state_next = S_NUM;
          endcase
        end
      end
      S_NUM: begin
        op = DP_NUM;
        if (stat.pend == OP_MUL || (stat.pend == OP_DIV && !stat.num_zero)) begin
          state_next = S_UNIT;
        end else begin
          state_next = S_POST;
        end
      end
      S_UNIT: begin
        op = DP_STEP;
        if (stat.unit_last) begin
          state_next = S_WB;
        end
      end
      S_WB: begin
        op         = DP_WB;
        state_next = S_POST;
      end
      S_POST: begin
        if (final_q) begin
          op         = DP_TERM;
          state_next = S_RES;
        end else begin
          case (cls)
            CLS_ADD: op = DP_TERM_ADD;
            CLS_SUB: op = DP_TERM_SUB;
            CLS_MUL: op = DP_PEND_MUL;
            CLS_DIV: op = DP_PEND_DIV;
            default: op = DP_NOP;
          endcase
          // closing an operator that ends the formula reads an empty number
          if (last_q) begin
            final_next = 1'b1;
            state_next = S_NUM;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_RES: begin
        if (!out_valid || out_ready) begin
          op         = DP_RESULT;
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/infix_arithmetic_evaluator_core.sv
// Infix arithmetic evaluator: takes a formula one ASCII character per transfer on
// chars and, after the transfer flagged last_char, returns one transfer on results
// with the formula value in signed fixed point (16 fraction bits, saturating) and a
// status (ok, division by zero with value 0, or overflow). Numbers are unsigned
// decimal, up to 10 digits (extra digits are dropped, an empty number reads as 0);
// + - * / are the operators, * and / bind tighter and run left to right, every
// other character is skipped. An operator closes the number before it, runs any
// multiplication (64 shift/add steps and a write-back) or division (79 restoring
// steps, one quotient bit per cycle, and a write-back) that the number closes on
// the single iterative multiply/divide unit, and then closes or opens a term; the
// input is held off meanwhile. The last character adds one more number close, a
// term close and the output load. A finished result sits in an output register, so
// characters of the next formula are taken while it waits; the output side stalls
// only when a second result is ready before the first is taken.
module infix_arithmetic_evaluator_core (
  input logic          clk,
  input logic          rst,
  iae_char_if.sink     chars,
  iae_result_if.source results
);
  import iae_pkg::*;

  dp_op_t   dp_op;
  dp_stat_t dp_stat;

  // Controller: handshakes and sequencing of each character's work
  iae_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chars.valid),
    .in_ready  (chars.ready),
    .char_code (chars.char_code),
    .last_char (chars.last_char),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .op        (dp_op),
    .stat      (dp_stat)
  );

  // Datapath: number build-up, term and sum registers, multiply/divide unit,
  // and the result register
  iae_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .char_code    (chars.char_code),
    .op           (dp_op),
    .stat         (dp_stat),
    .result_value (results.result_value),
    .status       (results.status)
  );

endmodule

// File: hw/rtl/iae_checker.sv
module iae_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_last,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [iae_pkg::DATA_W-1:0] out_value,
  input logic [1:0]                        out_status
);
  import iae_pkg::*;

  // Hold a pending result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_status))
    else $error("result payload changed while stalled");

  // Division by zero always reports a zero value
  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_DIV0 |-> out_value == '0)
    else $error("division by zero with nonzero value");

  // Closing a formula stalls the input in the cycle after the last character is taken
  a_last_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken right after the last character");

  // A new result only appears after the input has been held off
  a_res_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result raised without evaluation");

endmodule

bind infix_arithmetic_evaluator_core iae_checker u_iae_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (chars.valid),
  .in_ready   (chars.ready),
  .in_last    (chars.last_char),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_value  (results.result_value),
  .out_status (results.status)
);
